### rtl/core/afi_pkg.sv
// ----------------------------------------------------------------------------
// Affine inverse package
// Shared types, constants and the micro-operation program of the inverse unit.
// ----------------------------------------------------------------------------
package afi_pkg;

  localparam int NUM_ELEMS = 12;
  localparam int IDX_W     = 4;
  localparam int THR_W     = 31;
  localparam logic [IDX_W-1:0] LAST_ELEM = 4'd11;

  // Command passed from the front end to the back end through the queue.
  typedef struct packed {
    logic             wr;    // element index is in range, store the value
    logic [IDX_W-1:0] idx;
    logic             last;  // run the inverse after this element
  } cmd_ctl_t;

  // Source of the wide multiplier operand.
  typedef enum logic [1:0] {
    XS_ELEM = 2'd0,
    XS_ADJ  = 2'd1,
    XS_RES  = 2'd2
  } x_src_e;

  typedef enum logic [1:0] {
    ACC_LOAD = 2'd0,
    ACC_ADD  = 2'd1,
    ACC_SUB  = 2'd2
  } acc_e;

  typedef enum logic [1:0] {
    POST_NONE = 2'd0,
    POST_ADJ  = 2'd1,
    POST_DET  = 2'd2,
    POST_TR   = 2'd3
  } post_e;

  typedef struct packed {
    x_src_e           x_src;
    logic [IDX_W-1:0] x_idx;
    logic [IDX_W-1:0] y_idx;  // always a matrix element
    acc_e             acc;
    post_e            post;
    logic [IDX_W-1:0] dst;
  } op_t;

  localparam int NUM_OPS     = 30;
  localparam int TR_OP_FIRST = 21;
  localparam int NUM_DIVS    = 9;

  // Adjugate entries (two products each), determinant, then translation.
  localparam op_t OPS [NUM_OPS] = '{
    '{XS_ELEM, 4'd5,  4'd10, ACC_LOAD, POST_NONE, 4'd0},
    '{XS_ELEM, 4'd6,  4'd9,  ACC_SUB,  POST_ADJ,  4'd0},
    '{XS_ELEM, 4'd2,  4'd9,  ACC_LOAD, POST_NONE, 4'd0},
    '{XS_ELEM, 4'd1,  4'd10, ACC_SUB,  POST_ADJ,  4'd1},
    '{XS_ELEM, 4'd1,  4'd6,  ACC_LOAD, POST_NONE, 4'd0},
    '{XS_ELEM, 4'd2,  4'd5,  ACC_SUB,  POST_ADJ,  4'd2},
    '{XS_ELEM, 4'd6,  4'd8,  ACC_LOAD, POST_NONE, 4'd0},
    '{XS_ELEM, 4'd4,  4'd10, ACC_SUB,  POST_ADJ,  4'd3},
    '{XS_ELEM, 4'd0,  4'd10, ACC_LOAD, POST_NONE, 4'd0},
    '{XS_ELEM, 4'd2,  4'd8,  ACC_SUB,  POST_ADJ,  4'd4},
    '{XS_ELEM, 4'd2,  4'd4,  ACC_LOAD, POST_NONE, 4'd0},
    '{XS_ELEM, 4'd0,  4'd6,  ACC_SUB,  POST_ADJ,  4'd5},
    '{XS_ELEM, 4'd4,  4'd9,  ACC_LOAD, POST_NONE, 4'd0},
    '{XS_ELEM, 4'd5,  4'd8,  ACC_SUB,  POST_ADJ,  4'd6},
    '{XS_ELEM, 4'd1,  4'd8,  ACC_LOAD, POST_NONE, 4'd0},
    '{XS_ELEM, 4'd0,  4'd9,  ACC_SUB,  POST_ADJ,  4'd7},
    '{XS_ELEM, 4'd0,  4'd5,  ACC_LOAD, POST_NONE, 4'd0},
    '{XS_ELEM, 4'd1,  4'd4,  ACC_SUB,  POST_ADJ,  4'd8},
    '{XS_ADJ,  4'd0,  4'd0,  ACC_LOAD, POST_NONE, 4'd0},
    '{XS_ADJ,  4'd3,  4'd1,  ACC_ADD,  POST_NONE, 4'd0},
    '{XS_ADJ,  4'd6,  4'd2,  ACC_ADD,  POST_DET,  4'd0},
    '{XS_RES,  4'd0,  4'd3,  ACC_LOAD, POST_NONE, 4'd0},
    '{XS_RES,  4'd1,  4'd7,  ACC_ADD,  POST_NONE, 4'd0},
    '{XS_RES,  4'd2,  4'd11, ACC_ADD,  POST_TR,   4'd3},
    '{XS_RES,  4'd4,  4'd3,  ACC_LOAD, POST_NONE, 4'd0},
    '{XS_RES,  4'd5,  4'd7,  ACC_ADD,  POST_NONE, 4'd0},
    '{XS_RES,  4'd6,  4'd11, ACC_ADD,  POST_TR,   4'd7},
    '{XS_RES,  4'd8,  4'd3,  ACC_LOAD, POST_NONE, 4'd0},
    '{XS_RES,  4'd9,  4'd7,  ACC_ADD,  POST_NONE, 4'd0},
    '{XS_RES,  4'd10, 4'd11, ACC_ADD,  POST_TR,   4'd11}
  };

  // Result position of each linear-part quotient, in adjugate order.
  localparam logic [IDX_W-1:0] DIV_DST [NUM_DIVS] = '{
    4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9, 4'd10
  };

endpackage

### rtl/core/afi_front.sv
// ----------------------------------------------------------------------------
// Affine inverse front end
// Accepts element transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module afi_front #(
  parameter int VW = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [afi_pkg::IDX_W-1:0]      element_index_i,
  input  logic [VW-1:0]                  element_value_i,
  input  logic                           is_last_i,
  output logic                           cmd_valid_o,
  output afi_pkg::cmd_ctl_t              cmd_ctl_o,
  output logic [VW-1:0]                  cmd_value_o,
  input  logic                           cmd_ready_i
);

  afi_pkg::cmd_ctl_t ctl_q [2];
  logic [VW-1:0]     val_q [2];
  logic              wp_q, rp_q;
  logic [1:0]        cnt_q;
  logic              push, pop;
  afi_pkg::cmd_ctl_t ctl_in;

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_ctl_o   = ctl_q[rp_q];
  assign cmd_value_o = val_q[rp_q];

  always_comb begin
    ctl_in.wr   = (element_index_i < 4'(afi_pkg::NUM_ELEMS));
    ctl_in.idx  = element_index_i;
    ctl_in.last = is_last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctl_q[wp_q] <= ctl_in;
      val_q[wp_q] <= element_value_i;
    end
  end

endmodule

### rtl/core/afi_mul.sv
// ----------------------------------------------------------------------------
// Affine inverse multiplier
// Signed multiplier, eight bits of the narrow operand per cycle, top digit first.
// ----------------------------------------------------------------------------
module afi_mul #(
  parameter int XW = 65,
  parameter int YW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [XW-1:0]        x_i,
  input  logic [YW-1:0]        y_i,
  output logic                 done_o,
  output logic [XW+YW-1:0]     prod_o
);

  localparam int D  = (YW + 7) / 8;
  localparam int EW = 8 * D;
  localparam int MW = XW + EW + 1;
  localparam int CW = $clog2(D + 1);

  logic [XW-1:0]       x_q;
  logic [EW-1:0]       y_q;
  logic [MW-1:0]       acc_q;
  logic [CW-1:0]       cnt_q;
  logic                active_q, done_q;
  logic [7:0]          top;
  logic signed [8:0]   dig;
  logic signed [XW+8:0] pp;
  logic [MW-1:0]       acc_nxt;

  assign top = y_q[EW-1 -: 8];
  // Only the most significant digit carries the sign.
  assign dig = (cnt_q == '0) ? $signed({top[7], top}) : $signed({1'b0, top});
  assign pp  = $signed(x_q) * dig;
  assign acc_nxt = (acc_q << 8) + {{(MW-XW-9){pp[XW+8]}}, pp};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(D - 1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      y_q   <= {{(EW-YW){y_i[YW-1]}}, y_i};
      acc_q <= '0;
    end else if (active_q) begin
      acc_q <= acc_nxt;
      y_q   <= y_q << 8;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q[XW+YW-1:0];

endmodule

### rtl/core/afi_div.sv
// ----------------------------------------------------------------------------
// Affine inverse divider
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module afi_div #(
  parameter int NW = 81,
  parameter int DW = 99
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DW-1:0]  den_i,
  output logic           done_o,
  output logic [NW:0]    quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] un_q, q_q;
  logic [DW-1:0] ud_q, rem_q;
  logic          neg_q, active_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW:0]   rem_sh, rem_sub;
  logic          ge;

  assign rem_sh  = {rem_q, un_q[NW-1]};
  assign rem_sub = rem_sh - {1'b0, ud_q};
  assign ge      = (rem_sh >= {1'b0, ud_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(NW - 1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      un_q  <= num_i[NW-1] ? (~num_i + NW'(1)) : num_i;
      ud_q  <= den_i[DW-1] ? (~den_i + DW'(1)) : den_i;
      neg_q <= num_i[NW-1] ^ den_i[DW-1];
      rem_q <= '0;
      q_q   <= '0;
    end else if (active_q) begin
      rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      q_q   <= {q_q[NW-2:0], ge};
      un_q  <= un_q << 1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? (~{1'b0, q_q} + (NW+1)'(1)) : {1'b0, q_q};

endmodule

### rtl/core/afi_back.sv
// ----------------------------------------------------------------------------
// Affine inverse back end
// Element store, micro-op sequencer over the shared multiplier and divider,
// and result burst.
// ----------------------------------------------------------------------------
module afi_back #(
  parameter int VW = 32,
  parameter int FB = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  afi_pkg::cmd_ctl_t             cmd_ctl_i,
  input  logic [VW-1:0]                 cmd_value_i,
  output logic                          cmd_ready_o,
  input  logic [afi_pkg::THR_W-1:0]     threshold_i,
  output logic                          result_valid_o,
  output logic [afi_pkg::IDX_W-1:0]     result_index_o,
  output logic [VW-1:0]                 result_value_o,
  output logic                          singular_o,
  output logic                          last_result_o
);

  localparam int AW  = 2 * VW + 1;
  localparam int PW  = AW + VW;
  localparam int ACW = 3 * VW + 3;
  localparam int NW  = AW + FB;
  localparam int OPW = $clog2(afi_pkg::NUM_OPS);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_OPX     = 9'b000000010,
    S_OPY     = 9'b000000100,
    S_MULGO   = 9'b000001000,
    S_MULWAIT = 9'b000010000,
    S_CHECK   = 9'b000100000,
    S_DIVGO   = 9'b001000000,
    S_DIVWAIT = 9'b010000000,
    S_EMIT    = 9'b100000000
  } state_e;

  state_e                     state_q, state_d;
  logic [OPW-1:0]             op_q, op_d;
  logic [3:0]                 divk_q, divk_d;
  logic [3:0]                 emit_q, emit_d;
  logic                       sing_q, sing_d;
  afi_pkg::op_t               op;

  logic [VW-1:0]              mem [afi_pkg::NUM_ELEMS];
  logic [VW-1:0]              rd_q;
  logic [afi_pkg::IDX_W-1:0]  rd_addr;
  logic                       mem_we;

  logic [AW-1:0]              adj_q [afi_pkg::NUM_DIVS];
  logic [VW-1:0]              res_q [afi_pkg::NUM_ELEMS];
  logic [AW-1:0]              x_q;
  logic [ACW-1:0]             acc_q, det_q;
  logic [3:0]                 adj_ra, res_ra;
  logic [AW-1:0]              adj_rd;
  logic [VW-1:0]              res_rd;
  logic [AW-1:0]              x_sel;

  logic                       mul_start, mul_done;
  logic [PW-1:0]              prod;
  logic                       div_start, div_done;
  logic [NW:0]                quo;

  logic [ACW-1:0]             prod_ext, acc_nxt, acc_sh, det_mag;
  logic [ACW:0]               tr_v;
  logic                       is_sing;

  function automatic logic [VW-1:0] sat_acw(input logic [ACW:0] v);
    logic fits;
    fits = (v[ACW:VW-1] == '0) || (v[ACW:VW-1] == '1);
    if (fits) return v[VW-1:0];
    return v[ACW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
  endfunction

  function automatic logic [VW-1:0] sat_quo(input logic [NW:0] v);
    logic fits;
    fits = (v[NW:VW-1] == '0) || (v[NW:VW-1] == '1);
    if (fits) return v[VW-1:0];
    return v[NW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
  endfunction

  assign op          = afi_pkg::OPS[op_q];
  assign cmd_ready_o = (state_q == S_IDLE);
  assign mem_we      = cmd_valid_i && cmd_ready_o && cmd_ctl_i.wr;

  // Element store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[cmd_ctl_i.idx] <= cmd_value_i;
    rd_q <= mem[rd_addr];
  end

  assign rd_addr = (state_q == S_OPY) ? op.y_idx : op.x_idx;
  assign adj_ra  = (state_q == S_DIVGO) ? divk_q : op.x_idx;
  assign res_ra  = (state_q == S_EMIT) ? emit_q : op.x_idx;
  assign adj_rd  = adj_q[adj_ra];
  assign res_rd  = res_q[res_ra];

  always_comb begin
    unique case (op.x_src)
      afi_pkg::XS_ELEM: x_sel = {{(AW-VW){rd_q[VW-1]}}, rd_q};
      afi_pkg::XS_ADJ:  x_sel = adj_rd;
      afi_pkg::XS_RES:  x_sel = {{(AW-VW){res_rd[VW-1]}}, res_rd};
      default:          x_sel = '0;
    endcase
  end

  assign prod_ext = {{(ACW-PW){prod[PW-1]}}, prod};
  always_comb begin
    unique case (op.acc)
      afi_pkg::ACC_LOAD: acc_nxt = prod_ext;
      afi_pkg::ACC_ADD:  acc_nxt = acc_q + prod_ext;
      afi_pkg::ACC_SUB:  acc_nxt = acc_q - prod_ext;
      default:           acc_nxt = prod_ext;
    endcase
  end
  assign acc_sh = $signed(acc_nxt) >>> FB;
  assign tr_v   = ~{acc_sh[ACW-1], acc_sh} + (ACW+1)'(1);

  // A zero determinant is singular even with a zero threshold.
  assign det_mag = det_q[ACW-1] ? (~det_q + ACW'(1)) : det_q;
  assign is_sing = (det_q == '0) ||
                   (det_mag < {{(ACW-afi_pkg::THR_W){1'b0}}, threshold_i});

  assign mul_start = (state_q == S_MULGO);
  assign div_start = (state_q == S_DIVGO);

  afi_mul #(.XW(AW), .YW(VW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (x_q),
    .y_i     (rd_q),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  afi_div #(.NW(NW), .DW(ACW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({adj_rd, {FB{1'b0}}}),
    .den_i   (det_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    divk_d  = divk_q;
    emit_d  = emit_q;
    sing_d  = sing_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && cmd_ctl_i.last) begin
          op_d    = '0;
          state_d = S_OPX;
        end
      end
      S_OPX:   state_d = S_OPY;
      S_OPY:   state_d = S_MULGO;
      S_MULGO: state_d = S_MULWAIT;
      S_MULWAIT: begin
        if (mul_done) begin
          if (op.post == afi_pkg::POST_DET) begin
            state_d = S_CHECK;
          end else if (op_q == OPW'(afi_pkg::NUM_OPS - 1)) begin
            emit_d  = '0;
            state_d = S_EMIT;
          end else begin
            op_d    = op_q + OPW'(1);
            state_d = S_OPX;
          end
        end
      end
      S_CHECK: begin
        sing_d = is_sing;
        divk_d = '0;
        emit_d = '0;
        state_d = is_sing ? S_EMIT : S_DIVGO;
      end
      S_DIVGO: state_d = S_DIVWAIT;
      S_DIVWAIT: begin
        if (div_done) begin
          if (divk_q == 4'(afi_pkg::NUM_DIVS - 1)) begin
            op_d    = OPW'(afi_pkg::TR_OP_FIRST);
            state_d = S_OPX;
          end else begin
            divk_d  = divk_q + 4'd1;
            state_d = S_DIVGO;
          end
        end
      end
      S_EMIT: begin
        emit_d = emit_q + 4'd1;
        if (emit_q == afi_pkg::LAST_ELEM) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= '0;
      divk_q  <= '0;
      emit_q  <= '0;
      sing_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      divk_q  <= divk_d;
      emit_q  <= emit_d;
      sing_q  <= sing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OPY) x_q <= x_sel;
    if (state_q == S_MULWAIT && mul_done) begin
      acc_q <= acc_nxt;
      unique case (op.post)
        afi_pkg::POST_ADJ: adj_q[op.dst] <= acc_sh[AW-1:0];
        afi_pkg::POST_DET: det_q <= acc_sh;
        afi_pkg::POST_TR:  res_q[op.dst] <= sat_acw(tr_v);
        default: ;
      endcase
    end
    if (state_q == S_CHECK && is_sing) begin
      for (int i = 0; i < afi_pkg::NUM_ELEMS; i++) begin
        res_q[i] <= (i % 5 == 0) ? (VW'(1) << FB) : '0;
      end
    end
    if (state_q == S_DIVWAIT && div_done) begin
      res_q[afi_pkg::DIV_DST[divk_q]] <= sat_quo(quo);
    end
  end

  assign result_valid_o = (state_q == S_EMIT);
  assign result_index_o = emit_q;
  assign result_value_o = res_rd;
  assign singular_o     = sing_q;
  assign last_result_o  = (state_q == S_EMIT) && (emit_q == afi_pkg::LAST_ELEM);

endmodule

### rtl/core/affine_matrix_inverse_unit.sv
// ----------------------------------------------------------------------------
// Affine matrix inverse unit
// Inverts a 3x4 affine matrix in signed fixed point, one element per transaction.
// ----------------------------------------------------------------------------
// Usage:
// Elements arrive on the command channel: a transaction is taken at a clock
// edge where start is high and busy is low. element_index_i gives the
// row-major position (row*4+column); indexes 12 to 15 store nothing. A
// transaction with is_last_i set starts the inverse once its element is stored.
// A two-entry queue sits between the front end and the back end, so busy only
// rises when two transactions wait behind a running inverse.
// Each run produces a burst of twelve results, one per cycle, flagged by
// result_valid_o, with last_result_o on the twelfth. The receiver cannot stall;
// results must be taken in the cycle they appear.
// The serial divider (one quotient bit per cycle, nine divisions) takes most of
// a run's time; the shared multiplier takes eight narrow-operand bits per cycle.
// Reset clears the control logic and sets the singular threshold to one LSB;
// the element store holds no defined values until written. The threshold is
// written through the cfg channel, which is always ready.
module affine_matrix_inverse_unit #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [afi_pkg::IDX_W-1:0]     element_index_i,
  input  logic [VALUE_WIDTH-1:0]        element_value_i,
  input  logic                          is_last_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [afi_pkg::THR_W-1:0]     cfg_data_i,
  output logic                          result_valid_o,
  output logic [afi_pkg::IDX_W-1:0]     result_index_o,
  output logic [VALUE_WIDTH-1:0]        result_value_o,
  output logic                          singular_o,
  output logic                          last_result_o
);

  logic [afi_pkg::THR_W-1:0] thr_q;
  logic                      cmd_valid, cmd_ready;
  afi_pkg::cmd_ctl_t         cmd_ctl;
  logic [VALUE_WIDTH-1:0]    cmd_value;

  // The threshold register takes a write in any cycle; the user must see that
  // writes are only issued while no run is in flight; no logic enforces it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= afi_pkg::THR_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  afi_front #(.VW(VALUE_WIDTH)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .element_index_i (element_index_i),
    .element_value_i (element_value_i),
    .is_last_i       (is_last_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_ctl_o       (cmd_ctl),
    .cmd_value_o     (cmd_value),
    .cmd_ready_i     (cmd_ready)
  );

  afi_back #(.VW(VALUE_WIDTH), .FB(FRAC_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_ctl_i      (cmd_ctl),
    .cmd_value_i    (cmd_value),
    .cmd_ready_o    (cmd_ready),
    .threshold_i    (thr_q),
    .result_valid_o (result_valid_o),
    .result_index_o (result_index_o),
    .result_value_o (result_value_o),
    .singular_o     (singular_o),
    .last_result_o  (last_result_o)
  );

endmodule

### rtl/core/afi_checker.sv
// ----------------------------------------------------------------------------
// Affine inverse port checker
// Checks the shape of the result burst as seen on the top-level ports.
// ----------------------------------------------------------------------------
module afi_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      result_valid_i,
  input logic [afi_pkg::IDX_W-1:0] result_index_i,
  input logic                      singular_i,
  input logic                      last_result_i
);

  a_last_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_result_i |-> result_valid_i && (result_index_i == afi_pkg::LAST_ELEM))
    else $error("last result flag off the final burst position");

  a_burst_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_i) |-> (result_index_i == '0))
    else $error("result burst does not start at index zero");

  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && !last_result_i |=>
      result_valid_i && (result_index_i == $past(result_index_i) + 4'd1))
    else $error("result burst broken or out of order");

  a_singular_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_i && !last_result_i |=> (singular_i == $past(singular_i)))
    else $error("singular flag changed within a burst");

endmodule

bind affine_matrix_inverse_unit afi_checker u_afi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_i (result_valid_o),
  .result_index_i (result_index_o),
  .singular_i     (singular_o),
  .last_result_i  (last_result_o)
);
